### hw/rtl/assert_macros.svh
// Assertion helper macros for the PLL divider search RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### hw/rtl/plldiv_pkg.sv
// Shared widths, limits, default codes and controller/datapath bundles
// for the PLL divider search. No dependencies.
`default_nettype none

package plldiv_pkg;

    localparam int FIN_W  = 25;   // reference frequency
    localparam int TGT_W  = 32;   // requested frequency
    localparam int FREQ_W = 28;   // scaled target / achieved frequency
    localparam int NR_W   = 6;    // reference divider 2..33
    localparam int NF_W   = 10;   // feedback divider 2..513
    localparam int VCO_W  = 34;   // pfd * nf before window check
    localparam int DEN_W  = 8;    // divisor of the shared divider
    localparam int PROD_W = FIN_W + NF_W;

    // configuration register indexes
    localparam logic CFG_CRYSTAL = 1'b0;
    localparam logic CFG_RC      = 1'b1;

    localparam logic [FIN_W-1:0] CRYSTAL_RESET = 25'd12000000;
    localparam logic [FIN_W-1:0] RC_RESET      = 25'd22118400;

    localparam logic [TGT_W-1:0] LO_BAND_MIN  = 32'd25000000;
    localparam logic [TGT_W-1:0] LO_BAND_MAX  = 32'd50000000;
    localparam logic [TGT_W-1:0] MID_BAND_MAX = 32'd100000000;
    localparam logic [TGT_W-1:0] HI_BAND_MAX  = 32'd200000000;

    localparam logic [FIN_W-1:0] PFD_MIN = 25'd1600000;
    localparam logic [FIN_W-1:0] PFD_MAX = 25'd16000000;
    localparam logic [VCO_W-1:0] VCO_MIN = 34'd100000000;
    localparam logic [VCO_W-1:0] VCO_MAX = 34'd200000000;

    localparam logic [NR_W-1:0] NR_FIRST_XTAL = 6'd2;
    localparam logic [NR_W-1:0] NR_FIRST_RC   = 6'd4;
    localparam logic [NR_W-1:0] NR_LAST       = 6'd33;
    localparam logic [NF_W-1:0] NF_FIRST      = 10'd2;
    localparam logic [NF_W-1:0] NF_LAST       = 10'd513;

    // output divider codes per band
    localparam logic [1:0] ODIV_BY1 = 2'd0;
    localparam logic [1:0] ODIV_BY2 = 2'd1;
    localparam logic [1:0] ODIV_BY4 = 2'd3;

    // fallback setting words: {code[15:14], nr-2 [13:9], nf-2 [8:0]}
    localparam logic [15:0] DEF_XTAL_WORD = 16'hC22E;
    localparam logic [15:0] DEF_RC_WORD   = 16'hD66F;

    localparam logic [1:0]  DEF_XTAL_CODE = DEF_XTAL_WORD[15:14];
    localparam logic [4:0]  DEF_XTAL_NRC  = DEF_XTAL_WORD[13:9];
    localparam logic [8:0]  DEF_XTAL_NFC  = DEF_XTAL_WORD[8:0];
    localparam logic [1:0]  DEF_RC_CODE   = DEF_RC_WORD[15:14];
    localparam logic [4:0]  DEF_RC_NRC    = DEF_RC_WORD[13:9];
    localparam logic [8:0]  DEF_RC_NFC    = DEF_RC_WORD[8:0];

    typedef struct packed {
        logic load_in;      // capture request and reference
        logic div_start;    // launch the shared divider
        logic div_sel_out;  // 0: fin/nr, 1: fin/((code+1)*nr)
        logic nf_init;      // vco = 2*pfd, nf = 2
        logic nf_step;      // score candidate, advance nf
        logic nr_inc;       // next reference divider
        logic mult;         // quotient * nf
        logic out_load;     // fill the output register
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic in_band;
        logic pfd_ok;
        logic nf_end;
        logic nr_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/pll_divider_search.sv
// PLL divider search. One request word on the s_ side names the reference
// (crystal or internal RC) and a target output frequency in Hz; one result
// word on the m_ side gives the output divider code, NR-2, NF-2, the
// frequency actually reached and a flag set when fallback codes were used.
// The target band picks the output divider (25-50 MHz divide by 4, above
// 50-100 MHz by 2, above 100-200 MHz by 1); the block then tries NR from 2
// (crystal) or 4 (RC) to 33, keeping only NR whose comparison frequency lies
// strictly between 1.6 and 16 MHz, and for each scans NF upwards from 2,
// scoring pairs whose VCO lies within 100-200 MHz and keeping the first
// pair with the smallest error. The NF scan of an NR ends at an exact hit
// or once the VCO leaves the window. Targets out of band, or references
// with no usable pair, return the fixed fallback setting for the chosen
// reference with used_default set. One request is in work at a time. Each
// NR runs an integer division (a shared restoring divider, one bit a cycle,
// 25 bits), the comparison frequency check and the step to the next NR; an
// NR that passes the check also scores each NF tried. The VCO passes 200 MHz
// by NF 125 at the latest, so an NR scans at most 124 NF values. The final
// frequency needs another division, a multiply and the output load. s_tready
// is high only while no request is in work; a finished word waits in the
// output register, so the next request can be taken while it is still
// pending on m_. Reference frequencies are to be written through the cfg_
// port between requests; the block does not enforce this. They hold their
// reset values (12 MHz crystal, 22.1184 MHz RC) until then.
`default_nettype none

module pll_divider_search (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration: index 0 crystal frequency, 1 RC oscillator frequency
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire [24:0]  cfg_wdata,
    // request
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,    // [31:0] target_freq
    input  wire         s_tuser,    // [0] ref_source
    // result
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,    // [1:0] out_div_code, [6:2] ref_div_code,
                                    // [15:7] fb_div_code, [43:16] achieved_freq,
                                    // [47:44] zero
    output logic        m_tuser     // [0] used_default
);
    import plldiv_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [1:0]        out_div_code;
    logic [4:0]        ref_div_code;
    logic [8:0]        fb_div_code;
    logic [FREQ_W-1:0] achieved_freq;

    plldiv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    plldiv_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_ref_source   (s_tuser),
        .in_target_freq  (s_tdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_out_div_code  (out_div_code),
        .m_ref_div_code  (ref_div_code),
        .m_fb_div_code   (fb_div_code),
        .m_achieved_freq (achieved_freq),
        .m_used_default  (m_tuser)
    );

    assign m_tdata = {4'b0000, achieved_freq, fb_div_code, ref_div_code, out_div_code};

endmodule

`default_nettype wire

### hw/rtl/plldiv_divider.sv
// Restoring divider, one quotient bit a cycle, for the PLL divider search.
// Depends on plldiv_pkg for widths.
`default_nettype none

module plldiv_divider (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire [plldiv_pkg::FIN_W-1:0]   dividend,
    input  wire [plldiv_pkg::DEN_W-1:0]   divisor,
    output logic                          busy,
    output logic                          done,
    output logic [plldiv_pkg::FIN_W-1:0]  quotient
);
    import plldiv_pkg::*;

    localparam int CNT_W = $clog2(FIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FIN_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [FIN_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[FIN_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[FIN_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/plldiv_datapath.sv
// Datapath of the PLL divider search: config registers, band decode, NR/NF
// scan registers, shared divider, final multiply and output register.
// Depends on plldiv_pkg, plldiv_divider and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module plldiv_datapath (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire                               cfg_index,
    input  wire [plldiv_pkg::FIN_W-1:0]       cfg_wdata,
    input  wire                               in_ref_source,
    input  wire [plldiv_pkg::TGT_W-1:0]       in_target_freq,
    input  plldiv_pkg::cmd_t                  cmd,
    output plldiv_pkg::sts_t                  sts,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [1:0]                        m_out_div_code,
    output logic [4:0]                        m_ref_div_code,
    output logic [8:0]                        m_fb_div_code,
    output logic [plldiv_pkg::FREQ_W-1:0]     m_achieved_freq,
    output logic                              m_used_default
);
    import plldiv_pkg::*;

    logic [FIN_W-1:0]   crystal_reg, rc_reg;
    logic               rc_sel_reg;
    logic [FIN_W-1:0]   fin_reg;
    logic [FREQ_W-1:0]  tgt_reg, tgt_next;
    logic [1:0]         code_reg, code_next;
    logic               in_band_reg, in_band_next;
    logic [NR_W-1:0]    nr_reg;
    logic [NF_W-1:0]    nf_reg;
    logic [VCO_W-1:0]   vco_reg;
    logic               best_valid_reg;
    logic [NR_W-1:0]    best_nr_reg;
    logic [NF_W-1:0]    best_nf_reg;
    logic [FREQ_W-1:0]  best_err_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               m_valid_reg;
    logic [1:0]         o_code_reg;
    logic [4:0]         o_nrc_reg;
    logic [8:0]         o_nfc_reg;
    logic [FREQ_W-1:0]  o_freq_reg;
    logic               o_def_reg;

    logic               div_busy, div_done;
    logic [FIN_W-1:0]   quo;
    logic [DEN_W-1:0]   divisor;
    logic [DEN_W-1:0]   odiv;
    logic [2*DEN_W-1:0] den_full;

    logic               in_win;
    logic [FREQ_W-1:0]  err;
    logic               better;
    logic               use_def;
    logic [1:0]         sel_code;
    logic [NR_W-1:0]    sel_nr;
    logic [NF_W-1:0]    sel_nf;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crystal_reg <= CRYSTAL_RESET;
            rc_reg      <= RC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CRYSTAL: crystal_reg <= cfg_wdata;
                CFG_RC:      rc_reg      <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // band decode; target scaled onto the VCO range
    always_comb begin
        in_band_next = 1'b1;
        code_next    = ODIV_BY1;
        tgt_next     = in_target_freq[FREQ_W-1:0];
        if (in_target_freq >= LO_BAND_MIN && in_target_freq <= LO_BAND_MAX) begin
            code_next = ODIV_BY4;
            tgt_next  = {in_target_freq[FREQ_W-3:0], 2'b00};
        end else if (in_target_freq > LO_BAND_MAX && in_target_freq <= MID_BAND_MAX) begin
            code_next = ODIV_BY2;
            tgt_next  = {in_target_freq[FREQ_W-2:0], 1'b0};
        end else if (in_target_freq > MID_BAND_MAX && in_target_freq <= HI_BAND_MAX) begin
            code_next = ODIV_BY1;
        end else begin
            in_band_next = 1'b0;
        end
    end

    // candidate scoring
    assign in_win = (vco_reg >= VCO_MIN) && (vco_reg <= VCO_MAX);
    assign err    = (vco_reg[FREQ_W-1:0] > tgt_reg) ? vco_reg[FREQ_W-1:0] - tgt_reg
                                                    : tgt_reg - vco_reg[FREQ_W-1:0];
    assign better = in_win && (!best_valid_reg || err < best_err_reg);

    // final selection, fallback when out of band or nothing fit
    assign use_def  = !in_band_reg || !best_valid_reg;
    assign sel_code = use_def ? (rc_sel_reg ? DEF_RC_CODE : DEF_XTAL_CODE) : code_reg;
    assign sel_nr   = use_def ? NR_W'({1'b0, rc_sel_reg ? DEF_RC_NRC : DEF_XTAL_NRC}) + 6'd2
                              : best_nr_reg;
    assign sel_nf   = use_def ? NF_W'({1'b0, rc_sel_reg ? DEF_RC_NFC : DEF_XTAL_NFC}) + 10'd2
                              : best_nf_reg;

    assign odiv     = DEN_W'(sel_code) + 8'd1;
    assign den_full = odiv * DEN_W'(sel_nr);
    assign divisor  = cmd.div_sel_out ? den_full[DEN_W-1:0] : DEN_W'(nr_reg);

    plldiv_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (fin_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    // search registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
            in_band_reg    <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                best_valid_reg <= 1'b0;
                in_band_reg    <= in_band_next;
            end else if (cmd.nf_step && better) begin
                best_valid_reg <= 1'b1;
            end
        end
        if (cmd.load_in) begin
            rc_sel_reg <= in_ref_source;
            fin_reg    <= in_ref_source ? rc_reg : crystal_reg;
            tgt_reg    <= tgt_next;
            code_reg   <= code_next;
            nr_reg     <= in_ref_source ? NR_FIRST_RC : NR_FIRST_XTAL;
        end else if (cmd.nr_inc) begin
            nr_reg <= nr_reg + 1'b1;
        end
        if (cmd.nf_init) begin
            nf_reg  <= NF_FIRST;
            vco_reg <= {{(VCO_W-FIN_W-1){1'b0}}, quo, 1'b0};
        end else if (cmd.nf_step) begin
            nf_reg  <= nf_reg + 1'b1;
            vco_reg <= vco_reg + VCO_W'(quo);
        end
        if (cmd.nf_step && better) begin
            best_nr_reg  <= nr_reg;
            best_nf_reg  <= nf_reg;
            best_err_reg <= err;
        end
        if (cmd.mult) begin
            prod_reg <= quo * sel_nf;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            o_code_reg <= sel_code;
            o_nrc_reg  <= 5'(sel_nr - 6'd2);
            o_nfc_reg  <= 9'(sel_nf - 10'd2);
            o_freq_reg <= prod_reg[FREQ_W-1:0];
            o_def_reg  <= use_def;
        end
    end

    assign sts.div_done = div_done;
    assign sts.in_band  = in_band_reg;
    assign sts.pfd_ok   = (quo > PFD_MIN) && (quo < PFD_MAX);
    assign sts.nf_end   = (nf_reg == NF_LAST) || (vco_reg > VCO_MAX) || (in_win && err == '0);
    assign sts.nr_last  = (nr_reg == NR_LAST);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_out_div_code  = o_code_reg;
    assign m_ref_div_code  = o_nrc_reg;
    assign m_fb_div_code   = o_nfc_reg;
    assign m_achieved_freq = o_freq_reg;
    assign m_used_default  = o_def_reg;

    `ASSERT_NEVER(a_load_over_pending, aclk, aresetn, cmd.out_load && m_valid_reg && !m_ready)
    `ASSERT_NEVER(a_div_restart, aclk, aresetn, cmd.div_start && div_busy)
    `ASSERT_PROP(a_nf_in_range, aclk, aresetn, cmd.nf_step |-> (nf_reg >= NF_FIRST && nf_reg <= NF_LAST))
    `ASSERT_PROP(a_best_in_win, aclk, aresetn, (cmd.nf_step && better) |=> (best_valid_reg && best_err_reg <= VCO_MAX[FREQ_W-1:0]))

endmodule

`default_nettype wire

### hw/rtl/plldiv_ctrl.sv
// Sequencer of the PLL divider search: walks NR, the NF scan, the final
// division and the output hand-off. Depends on plldiv_pkg.
`default_nettype none

module plldiv_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  plldiv_pkg::sts_t  sts,
    output plldiv_pkg::cmd_t  cmd
);
    import plldiv_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b000_0000_0001,
        ST_SETUP      = 11'b000_0000_0010,
        ST_DIV_START  = 11'b000_0000_0100,
        ST_DIV_WAIT   = 11'b000_0000_1000,
        ST_PFD_CHECK  = 11'b000_0001_0000,
        ST_NF_SCAN    = 11'b000_0010_0000,
        ST_NR_NEXT    = 11'b000_0100_0000,
        ST_FDIV_START = 11'b000_1000_0000,
        ST_FDIV_WAIT  = 11'b001_0000_0000,
        ST_MULT       = 11'b010_0000_0000,
        ST_FINISH     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = sts.in_band ? ST_DIV_START : ST_FDIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_PFD_CHECK;
                end
            end
            ST_PFD_CHECK: begin
                if (sts.pfd_ok) begin
                    cmd.nf_init = 1'b1;
                    state_next  = ST_NF_SCAN;
                end else begin
                    state_next = ST_NR_NEXT;
                end
            end
            ST_NF_SCAN: begin
                cmd.nf_step = 1'b1;
                if (sts.nf_end) begin
                    state_next = ST_NR_NEXT;
                end
            end
            ST_NR_NEXT: begin
                if (sts.nr_last) begin
                    state_next = ST_FDIV_START;
                end else begin
                    cmd.nr_inc = 1'b1;
                    state_next = ST_DIV_START;
                end
            end
            ST_FDIV_START: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_out = 1'b1;
                state_next      = ST_FDIV_WAIT;
            end
            ST_FDIV_WAIT: begin
                cmd.div_sel_out = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking bench for pll_divider_search: drives request words on the s_ side,
// predicts each result word in-bench and checks the m_ side field by field.
// Depends on plldiv_pkg and the pll_divider_search RTL only.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plldiv_pkg::*;

    // one request word as the sender sees it
    typedef struct {
        logic        use_rc;
        logic [31:0] target;
    } pll_request_t;

    // one result word, split into its fields
    typedef struct packed {
        logic [1:0]  out_div_code;
        logic [4:0]  ref_div_code;
        logic [8:0]  fb_div_code;
        logic [27:0] achieved_freq;
        logic        used_default;
    } pll_setting_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_CRYSTAL;
    logic [24:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;

    // bench copy of the two reference registers
    logic [24:0] xtal_hz = CRYSTAL_RESET;
    logic [24:0] rc_hz   = RC_RESET;

    pll_request_t pending_reqs[$];
    pll_setting_t expected_settings[$];

    int unsigned req_sent  = 0;   // words put on s_ by the driver
    int unsigned req_taken = 0;   // words accepted by the block
    int unsigned errors    = 0;

    // idling control, set per phase by the stimulus block
    bit calm          = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap      = 0;
    int recv_stall    = 0;

    pll_divider_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Divider search as the block should do it: pick the band, then scan
    // NR x NF keeping the first strictly-best pair. Out of band, or with no
    // pair meeting the PFD/VCO windows, fall back to the fixed setting word
    // of the chosen reference and flag it.
    function automatic pll_setting_t search_dividers(input logic use_rc,
                                                     input logic [31:0] want);
        logic [24:0]  fin;
        logic [1:0]   code;
        logic [27:0]  goal;
        logic [24:0]  pfd;
        logic [34:0]  vco;
        logic [34:0]  err;
        logic [34:0]  best_err;
        logic [15:0]  fallback;
        logic [24:0]  quot;
        logic [34:0]  prod;
        logic         in_band;
        int           nr;
        int           nf;
        int           best_nr;
        int           best_nf;
        pll_setting_t res;
        fin      = use_rc ? rc_hz : xtal_hz;
        in_band  = 1'b1;
        code     = ODIV_BY1;
        goal     = want[27:0];
        best_nr  = 0;
        best_nf  = 0;
        best_err = '1;
        if (want >= LO_BAND_MIN && want <= LO_BAND_MAX) begin
            code = ODIV_BY4;
            goal = 28'(want << 2);
        end else if (want > LO_BAND_MAX && want <= MID_BAND_MAX) begin
            code = ODIV_BY2;
            goal = 28'(want << 1);
        end else if (want > MID_BAND_MAX && want <= HI_BAND_MAX) begin
            code = ODIV_BY1;
            goal = 28'(want);
        end else begin
            in_band = 1'b0;
        end
        if (in_band) begin
            for (nr = use_rc ? int'(NR_FIRST_RC) : int'(NR_FIRST_XTAL);
                 nr <= int'(NR_LAST); nr++) begin
                pfd = fin / nr;
                if (pfd > PFD_MIN && pfd < PFD_MAX) begin
                    for (nf = int'(NF_FIRST); nf <= int'(NF_LAST); nf++) begin
                        vco = pfd * nf;
                        if (vco >= VCO_MIN && vco <= VCO_MAX) begin
                            err = (vco > goal) ? vco - goal : goal - vco;
                            if (err < best_err) begin
                                best_err = err;
                                best_nr  = nr;
                                best_nf  = nf;
                                if (err == 0)
                                    break;   // exact hit ends this NR's scan
                            end
                        end
                    end
                end
            end
        end
        if (!in_band || best_nr == 0) begin
            fallback = use_rc ? DEF_RC_WORD : DEF_XTAL_WORD;
            code     = fallback[15:14];
            best_nr  = int'(fallback[13:9]) + 2;
            best_nf  = int'(fallback[8:0]) + 2;
            res.used_default = 1'b1;
        end else begin
            res.used_default = 1'b0;
        end
        // integer division first, then the multiply; kept to 28 bits
        quot = fin / ((int'(code) + 1) * best_nr);
        prod = quot * best_nf;
        res.out_div_code  = code;
        res.ref_div_code  = 5'(best_nr - 2);
        res.fb_div_code   = 9'(best_nf - 2);
        res.achieved_freq = prod[27:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Request driver: moves on only once the word on the bus has been taken,
    // and opens random gaps between words.
    always @(negedge aclk) begin : drive_requests
        pll_request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken == req_sent) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(99) < send_idle_pct) begin
                send_gap = $urandom_range(13, 0);
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req = pending_reqs.pop_front();
                s_tdata  <= req.target;
                s_tuser  <= req.use_rc;
                s_tvalid <= 1'b1;
                req_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, same burst shape as the sender.
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else if ($urandom_range(99) < recv_idle_pct) begin
            recv_stall = $urandom_range(13, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted request word, check every result word
    // against the oldest prediction.
    always @(posedge aclk) begin : watch_ports
        pll_setting_t got;
        pll_setting_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                req_taken++;
                expected_settings.push_back(search_dividers(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.out_div_code  = m_tdata[1:0];
                got.ref_div_code  = m_tdata[6:2];
                got.fb_div_code   = m_tdata[15:7];
                got.achieved_freq = m_tdata[43:16];
                got.used_default  = m_tuser;
                if (expected_settings.size() == 0) begin
                    $error("result word with nothing outstanding: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_settings.pop_front();
                    check_field("out_div_code", want.out_div_code, got.out_div_code);
                    check_field("ref_div_code", want.ref_div_code, got.ref_div_code);
                    check_field("fb_div_code", want.fb_div_code, got.fb_div_code);
                    check_field("achieved_freq", want.achieved_freq, got.achieved_freq);
                    check_field("used_default", want.used_default, got.used_default);
                    check_field("tdata padding", 0, m_tdata[47:44]);
                end
            end
        end
    end

    // Register write, only ever called with the block idle.
    task automatic write_ref(input logic idx, input logic [24:0] hz);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= hz;
        if (idx == CFG_RC)
            rc_hz = hz;
        else
            xtal_hz = hz;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_refs(input logic [24:0] xtal, input logic [24:0] rc);
        write_ref(CFG_CRYSTAL, xtal);
        write_ref(CFG_RC, rc);
    endtask

    task automatic queue_req(input logic use_rc, input logic [31:0] target);
        pll_request_t req;
        req.use_rc = use_rc;
        req.target = target;
        pending_reqs.push_back(req);
    endtask

    // Hold off until every word is sent, taken and answered.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (pending_reqs.size() != 0 || req_taken != req_sent ||
               expected_settings.size() != 0);
    endtask

    // Mostly in-band targets, some at or next to a band edge, some anywhere.
    function automatic logic [31:0] pick_target();
        int unsigned roll;
        logic [31:0] edges [4];
        edges = '{LO_BAND_MIN, LO_BAND_MAX, MID_BAND_MAX, HI_BAND_MAX};
        roll = $urandom_range(99);
        if (roll < 80)
            return $urandom_range(HI_BAND_MAX, LO_BAND_MIN);
        else if (roll < 90)
            return edges[$urandom_range(3)] + $urandom_range(4) - 2;
        else
            return $urandom;
    endfunction

    function automatic logic [24:0] pick_ref(input int unsigned lo, input int unsigned hi);
        if ($urandom_range(4) == 0)
            return 25'($urandom);   // anywhere in the register, often no usable pair
        return 25'($urandom_range(hi, lo));
    endfunction

    initial begin : stimulus
        int idle_steps [4];
        idle_steps = '{0, 3, 10, 25};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset references, both band edges, all-zero and
        // all-ones targets, out-of-band fallbacks and exact hits.
        send_idle_pct = 10;
        recv_idle_pct = 10;
        queue_req(1'b0, 32'd0);
        queue_req(1'b1, 32'hFFFF_FFFF);
        queue_req(1'b0, LO_BAND_MIN - 1);
        queue_req(1'b1, LO_BAND_MIN - 1);
        queue_req(1'b0, LO_BAND_MIN);
        queue_req(1'b1, LO_BAND_MAX);
        queue_req(1'b0, LO_BAND_MAX + 1);
        queue_req(1'b1, MID_BAND_MAX);
        queue_req(1'b0, MID_BAND_MAX + 1);
        queue_req(1'b1, HI_BAND_MAX);
        queue_req(1'b0, HI_BAND_MAX + 1);
        queue_req(1'b0, 32'd48_000_000);    // exact hit on 12 MHz
        queue_req(1'b1, 32'd147_456_000);   // exact hit on the RC reference
        wait_drained();

        // References with no usable pair at all, and the register maxima
        set_refs(25'd0, 25'h1FF_FFFF);
        queue_req(1'b0, 32'd150_000_000);
        queue_req(1'b1, 32'd75_000_000);
        queue_req(1'b1, 32'd30_000_000);
        wait_drained();
        set_refs(25'h1FF_FFFF, 25'd0);
        queue_req(1'b0, 32'd120_000_000);
        queue_req(1'b1, 32'd180_000_000);
        wait_drained();

        // In-range extremes of both references
        set_refs(25'd4_000_000, 25'd25_000_000);
        queue_req(1'b0, 32'd33_333_333);
        queue_req(1'b1, 32'd199_999_999);
        wait_drained();
        set_refs(25'd24_000_000, 25'd4_000_000);
        queue_req(1'b0, 32'd66_000_000);
        queue_req(1'b1, 32'd130_000_000);
        wait_drained();

        // Random phases; each one starts from an idle block with fresh
        // references, the last runs with no idling on either side.
        for (int phase = 0; phase < 6; phase++) begin
            calm = (phase == 5);
            send_idle_pct = calm ? 0 : idle_steps[$urandom_range(3)];
            recv_idle_pct = calm ? 0 : idle_steps[$urandom_range(3)];
            set_refs(pick_ref(4_000_000, 24_000_000), pick_ref(4_000_000, 25_000_000));
            repeat (13)
                queue_req(1'($urandom_range(1)), pick_target());
            wait_drained();
        end

        // nothing left outstanding; give any stray word time to show up
        repeat (500) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run of this stimulus.
    initial begin : watchdog
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
